// File: hdl/kca_pkg.sv
// Keyframe colour animator: shared constants, command/status structs and
// keyframe decode functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kca_pkg;

  localparam int KEY_REGS    = 6;
  localparam int MAX_KEYS    = 6;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 3;
  localparam int ELAP_W      = 8;
  localparam int TIME_W      = 17;
  localparam int DUR_W       = 16;
  localparam int LVL_W       = 8;
  localparam int RES_W       = 24;
  localparam int FRAC_W      = 16;
  localparam int QUO_W       = 17;
  localparam int WORD_W      = 48;
  localparam int CH_SHIFT    = 16;
  localparam int NUM_CH      = 4;
  localparam int DIV_STEPS   = QUO_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [QUO_W-1:0] ONE_FIX = 17'h10000;

  localparam int CFG_ADDR_W   = 6;
  localparam int CFG_DATA_W   = 64;
  localparam int REG_IDX_W    = 3;
  localparam int REG_ADDR_LSB = 3;

  localparam logic [REG_IDX_W-1:0] REG_KEY_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD0 = 3'd1;

  localparam logic [1:0] CH_RED    = 2'd0;
  localparam logic [1:0] CH_GREEN  = 2'd1;
  localparam logic [1:0] CH_BLUE   = 2'd2;
  localparam logic [1:0] CH_BRIGHT = 2'd3;

  typedef logic [KEY_REGS-1:0][WORD_W-1:0] key_words_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic div_step;
    logic mul;
    logic chan;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic div_last;
    logic chan_last;
  } dp_sts_t;

  function automatic logic [DUR_W-1:0] key_dur(input logic [WORD_W-1:0] w);
    logic [DUR_W-1:0] d;
    d = w[47:32];
    return (d == '0) ? DUR_W'(1) : d;
  endfunction

  function automatic logic [LVL_W-1:0] key_level(input logic [WORD_W-1:0] w,
                                                 input logic [1:0] ch);
    logic [LVL_W-1:0] l;
    unique case (ch)
      CH_RED:    l = w[31:24];
      CH_GREEN:  l = w[23:16];
      CH_BLUE:   l = w[15:8];
      CH_BRIGHT: l = w[7:0];
      default:   l = '0;
    endcase
    return l;
  endfunction

  function automatic logic [CNT_W-1:0] keys_in_use(input logic [CNT_W-1:0] kc);
    logic [CNT_W-1:0] n;
    if (kc == '0) begin
      n = CNT_W'(1);
    end else if (kc > CNT_W'(MAX_KEYS)) begin
      n = CNT_W'(MAX_KEYS);
    end else begin
      n = kc;
    end
    return n;
  endfunction

  function automatic logic [IDX_W-1:0] next_key(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] n);
    logic [IDX_W:0] inc;
    inc = {1'b0, idx} + (IDX_W+1)'(1);
    return (inc < {1'b0, n}) ? inc[IDX_W-1:0] : '0;
  endfunction

endpackage

`default_nettype wire

// File: hdl/kca_chan_if.sv
// Valid/ready channel interfaces for tick items and colour results.
// Depends on kca_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface kca_in_if import kca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELAP_W-1:0] elapsed_ticks;
  logic              restart;

  modport source (output valid, output elapsed_ticks, output restart, input ready);
  modport sink   (input valid, input elapsed_ticks, input restart, output ready);
endinterface

interface kca_out_if import kca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] red_level;
  logic [RES_W-1:0] green_level;
  logic [RES_W-1:0] blue_level;
  logic [RES_W-1:0] bright_level;
  logic [IDX_W-1:0] current_key;

  modport source (output valid, output red_level, output green_level,
                  output blue_level, output bright_level, output current_key,
                  input ready);
  modport sink   (input valid, input red_level, input green_level,
                  input blue_level, input bright_level, input current_key,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/kca_regs.sv
// APB register file: key count and six packed keyframe words.
// Depends on kca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kca_regs import kca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CNT_W-1:0]      key_count,
  output key_words_t            key_words
);

  logic [CNT_W-1:0]     key_count_r;
  key_words_t           key_words_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:REG_ADDR_LSB];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= CNT_W'(1);
      key_words_r <= '0;
    end else if (wr_en) begin
      if (reg_idx == REG_KEY_COUNT) begin
        key_count_r <= pwdata[CNT_W-1:0];
      end
      for (int k = 0; k < KEY_REGS; k++) begin
        if (reg_idx == REG_IDX_W'(k) + REG_KEY_WORD0) begin
          key_words_r[k] <= pwdata[WORD_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_KEY_COUNT) begin
      prdata = CFG_DATA_W'(key_count_r);
    end
    for (int k = 0; k < KEY_REGS; k++) begin
      if (reg_idx == REG_IDX_W'(k) + REG_KEY_WORD0) begin
        prdata = CFG_DATA_W'(key_words_r[k]);
      end
    end
  end

  assign key_count = key_count_r;
  assign key_words = key_words_r;

endmodule

`default_nettype wire

// File: hdl/kca_ctrl.sv
// Sequencing FSM: accept, key walk, reciprocal divide, fraction multiply,
// per-channel blend and result hand-off. Depends on kca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kca_ctrl import kca_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WALK = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_CHAN = 6'b010000,
    S_PUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHAN;
      end
      S_CHAN: begin
        cmd.chan = 1'b1;
        if (sts.chan_last) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_WALK)
    else $error("accepted tick did not start key walk");

  a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUSH))
    else $error("result raised outside hand-off");

  a_push_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUSH && out_valid_r && !out_ready |=> state_r == S_PUSH && out_valid_r)
    else $error("hand-off overran a pending result");
`endif

endmodule

`default_nettype wire

// File: hdl/kca_dp.sv
// Datapath: key index/time state, serial reciprocal divider, fraction
// multiplier, shared channel blend unit and output register. Depends on kca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kca_dp import kca_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [ELAP_W-1:0] elapsed_ticks,
  input  logic              restart,
  input  logic [CNT_W-1:0]  key_count,
  input  key_words_t        key_words,
  output logic [RES_W-1:0]  red_level,
  output logic [RES_W-1:0]  green_level,
  output logic [RES_W-1:0]  blue_level,
  output logic [RES_W-1:0]  bright_level,
  output logic [IDX_W-1:0]  current_key
);

  localparam int PROD_W = LVL_W + FRAC_W + 2;
  localparam int ACC_W  = PROD_W + 1;

  logic [IDX_W-1:0]     key_idx_r;
  logic [TIME_W-1:0]    time_r;
  logic [DUR_W-1:0]     div_rem_r;
  logic [QUO_W-1:0]     div_num_r;
  logic [QUO_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [FRAC_W-1:0]    frac_r;
  logic [1:0]           ch_r;
  logic [RES_W-1:0]     lvl_r [NUM_CH];
  logic [RES_W-1:0]     red_r, green_r, blue_r, bright_r;
  logic [IDX_W-1:0]     cur_key_r;

  logic [CNT_W-1:0]         n_keys;
  logic [WORD_W-1:0]        cur_word, nxt_word;
  logic [DUR_W-1:0]         dur;
  logic [IDX_W-1:0]         nxt_idx;
  logic [IDX_W-1:0]         base_idx, load_idx;
  logic [TIME_W-1:0]        base_time, load_time;
  logic                     walk_hit;
  logic [QUO_W-1:0]         div_trial, div_diff;
  logic                     div_ge;
  logic [QUO_W-1:0]         frac_prod;
  logic [LVL_W-1:0]         lvl_cur, lvl_nxt;
  logic signed [LVL_W:0]    delta;
  logic signed [PROD_W-1:0] blend_prod;
  logic signed [ACC_W-1:0]  blend_acc;
  logic [RES_W-1:0]         blend_val;

  assign n_keys   = keys_in_use(key_count);
  assign cur_word = key_words[key_idx_r];
  assign dur      = key_dur(cur_word);
  assign nxt_idx  = next_key(key_idx_r, n_keys);
  assign nxt_word = key_words[nxt_idx];

  // restart, then wrap a stale index, then add the elapsed time
  assign base_idx  = restart ? '0 : key_idx_r;
  assign load_idx  = ({1'b0, base_idx} >= {1'b0, n_keys}) ? '0 : base_idx;
  assign base_time = restart ? '0 : time_r;
  assign load_time = TIME_W'({1'b0, base_time} + (TIME_W+1)'(elapsed_ticks));

  assign walk_hit = time_r >= TIME_W'(dur);

  assign div_trial = {div_rem_r, div_num_r[QUO_W-1]};
  assign div_ge    = div_trial >= QUO_W'(dur);
  assign div_diff  = div_trial - QUO_W'(dur);

  // time stays below the duration, so the fraction is under 0x10000
  assign frac_prod = time_r * quo_r;

  assign lvl_cur    = key_level(cur_word, ch_r);
  assign lvl_nxt    = key_level(nxt_word, ch_r);
  assign delta      = $signed({1'b0, lvl_nxt}) - $signed({1'b0, lvl_cur});
  assign blend_prod = PROD_W'(delta) * PROD_W'($signed({1'b0, frac_r}));
  assign blend_acc  = ACC_W'(blend_prod)
                    + $signed(ACC_W'({lvl_cur, {CH_SHIFT{1'b0}}}));
  assign blend_val  = blend_acc[ACC_W-1] ? '0 : blend_acc[RES_W-1:0];

  assign sts.walk_done = ~walk_hit;
  assign sts.div_last  = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
  assign sts.chan_last = ch_r == CH_BRIGHT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_idx_r <= '0;
      time_r    <= '0;
    end else if (cmd.load) begin
      key_idx_r <= load_idx;
      time_r    <= load_time;
    end else if (cmd.walk && walk_hit) begin
      key_idx_r <= nxt_idx;
      time_r    <= time_r - TIME_W'(dur);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
      ch_r      <= CH_RED;
    end else begin
      if (cmd.walk && !walk_hit) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.mul) begin
        ch_r <= CH_RED;
      end else if (cmd.chan) begin
        ch_r <= ch_r + 2'd1;
      end
    end
  end

  // restoring divide of 0x10000 by the current duration, one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.walk && !walk_hit) begin
      div_rem_r <= '0;
      div_num_r <= ONE_FIX;
      quo_r     <= '0;
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? div_diff[DUR_W-1:0] : div_trial[DUR_W-1:0];
      div_num_r <= {div_num_r[QUO_W-2:0], 1'b0};
      quo_r     <= {quo_r[QUO_W-2:0], div_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      frac_r <= frac_prod[FRAC_W-1:0];
    end
    if (cmd.chan) begin
      lvl_r[ch_r] <= blend_val;
    end
    if (cmd.push) begin
      red_r     <= lvl_r[CH_RED];
      green_r   <= lvl_r[CH_GREEN];
      blue_r    <= lvl_r[CH_BLUE];
      bright_r  <= lvl_r[CH_BRIGHT];
      cur_key_r <= key_idx_r;
    end
  end

  assign red_level    = red_r;
  assign green_level  = green_r;
  assign blue_level   = blue_r;
  assign bright_level = bright_r;
  assign current_key  = cur_key_r;

endmodule

`default_nettype wire

// File: hdl/keyframe_colour_animator.sv
// Keyframe colour animator top level: APB registers, controller and datapath.
// Per tick: a key walk (one key step a cycle), a serial reciprocal divider,
// 1 multiply and 4 blends, then a hand-off that waits while a result is still pending.
// One tick is worked at a time; a finished result waits in the output register.
// Synchronous active-low reset: key count 1, keyframes 0, key index and time 0.
// Depends on kca_pkg, kca_chan_if, kca_regs, kca_ctrl, kca_dp.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_colour_animator import kca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  kca_in_if.sink                in_ch,
  kca_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CNT_W-1:0] key_count;
  key_words_t       key_words;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  kca_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .key_count (key_count),
    .key_words (key_words)
  );

  kca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  kca_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .elapsed_ticks (in_ch.elapsed_ticks),
    .restart       (in_ch.restart),
    .key_count     (key_count),
    .key_words     (key_words),
    .red_level     (out_ch.red_level),
    .green_level   (out_ch.green_level),
    .blue_level    (out_ch.blue_level),
    .bright_level  (out_ch.bright_level),
    .current_key   (out_ch.current_key)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for keyframe_colour_animator: tick transfers in, colour transfers out,
// keyframes set over APB between phases. Expected colours come from a local keyframe walker.
// Depends on kca_pkg, kca_chan_if and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_top;
  import kca_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 300;
  localparam int PHASES = 10;
  localparam int PHASE_TICKS = 78;
  localparam int PHASE_KEYS [PHASES] = '{6, 1, 7, 0, 2, 5, 3, 4, 6, 7};
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum int {DUR_TINY, DUR_MID, DUR_WIDE, DUR_MIXED} span_mode_t;

  typedef struct packed {
    logic [ELAP_W-1:0] elapsed;
    logic              restart;
  } tick_t;

  typedef struct packed {
    logic [RES_W-1:0] red;
    logic [RES_W-1:0] green;
    logic [RES_W-1:0] blue;
    logic [RES_W-1:0] bright;
    logic [IDX_W-1:0] key;
  } colour_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  kca_in_if  in_bus ();
  kca_out_if out_bus ();

  keyframe_colour_animator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tick_t       ticks_pending [$];
  colour_t     colour_due [$];
  logic [CNT_W-1:0]  key_count_m;
  logic [WORD_W-1:0] key_mem [KEY_REGS];
  logic [IDX_W-1:0]  anim_key;
  logic [TIME_W-1:0] anim_time;
  bit          in_fire;
  bit          idling = 1'b1;
  bit          hold_go;
  bit          out_hold;
  int          tx_gap;
  int          rx_gap;
  int          mismatches;
  int unsigned cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [TIME_W-1:0] key_span(input logic [IDX_W-1:0] k);
    logic [DUR_W-1:0] d;
    d = key_mem[k][47:32];
    return (d == '0) ? TIME_W'(1) : TIME_W'(d);
  endfunction

  function automatic logic [LVL_W-1:0] key_shade(input logic [IDX_W-1:0] k, input int ch);
    return key_mem[k][31 - 8*ch -: 8];
  endfunction

  // advances the keyframe position by one tick item's elapsed time and blends the four channels
  function automatic colour_t animate_tick(input logic [ELAP_W-1:0] elapsed,
                                           input logic restart);
    int          n;
    int          nxt;
    int unsigned frac;
    longint      cur;
    longint      delta;
    longint      v;
    logic [RES_W-1:0] lvl [NUM_CH];
    colour_t     c;
    n = (key_count_m == '0) ? 1 : (key_count_m > MAX_KEYS) ? MAX_KEYS : int'(key_count_m);
    if (restart) begin
      anim_key = '0;
      anim_time = '0;
    end
    if (anim_key >= n) anim_key = '0;
    anim_time = anim_time + elapsed;
    while (anim_time >= key_span(anim_key)) begin
      anim_time = anim_time - key_span(anim_key);
      anim_key = (anim_key + 1 >= n) ? '0 : anim_key + 1'b1;
    end
    nxt = (anim_key + 1 < n) ? anim_key + 1 : 0;
    frac = anim_time * (32'(ONE_FIX) / key_span(anim_key));
    for (int ch = 0; ch < NUM_CH; ch++) begin
      cur = longint'(key_shade(anim_key, ch));
      delta = longint'(key_shade(IDX_W'(nxt), ch)) - cur;
      v = delta * longint'(frac) + (cur << CH_SHIFT);
      if (v < 0) v = 0;
      lvl[ch] = v[RES_W-1:0];
    end
    c.red = lvl[CH_RED];
    c.green = lvl[CH_GREEN];
    c.blue = lvl[CH_BLUE];
    c.bright = lvl[CH_BRIGHT];
    c.key = anim_key;
    return c;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx) << REG_ADDR_LSB;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_KEY_COUNT) begin
      key_count_m = val[CNT_W-1:0];
    end else if (int'(idx) >= int'(REG_KEY_WORD0) && int'(idx) < int'(REG_KEY_WORD0) + KEY_REGS) begin
      key_mem[idx - REG_KEY_WORD0] = val[WORD_W-1:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (ticks_pending.size() != 0 || colour_due.size() != 0) @(negedge clk);
  endtask

  function automatic void queue_tick(input int elapsed, input bit restart);
    ticks_pending.push_back('{elapsed: ELAP_W'(elapsed), restart: restart});
  endfunction

  task automatic random_phase(input int kc, input span_mode_t mode, input int count,
                              input bit keep_keys);
    logic [DUR_W-1:0] dur;
    logic [31:0]      shades;
    wait_idle();
    if (!keep_keys) begin
      reg_write(REG_KEY_COUNT, {$urandom, 29'($urandom), 3'(kc)});
      for (int k = 0; k < KEY_REGS; k++) begin
        case (mode)
          DUR_TINY:  dur = 16'($urandom_range(0, 12));
          DUR_MID:   dur = 16'($urandom_range(16, 700));
          DUR_WIDE:  dur = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
          default:   dur = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom_range(1, 60));
        endcase
        shades = $urandom;
        if ($urandom_range(0, 5) == 0) shades = '0;
        else if ($urandom_range(0, 5) == 0) shades = '1;
        reg_write(REG_KEY_WORD0 + REG_IDX_W'(k), {16'($urandom), dur, shades});
      end
    end
    @(posedge clk);
    for (int i = 0; i < count; i++) begin
      queue_tick(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255),
                 $urandom_range(0, 15) == 0);
    end
  endtask

  // tick driver
  always @(negedge clk) begin : drive_ticks
    int gap_now;
    gap_now = tx_gap;
    if (in_fire && idling && $urandom_range(0, 3) == 0) gap_now = $urandom_range(1, 4);
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (gap_now > 0) begin
      gap_now--;
      in_bus.valid <= 1'b0;
    end else if (ticks_pending.size() > 0) begin
      in_bus.valid <= 1'b1;
      in_bus.elapsed_ticks <= ticks_pending[0].elapsed;
      in_bus.restart <= ticks_pending[0].restart;
    end else begin
      in_bus.valid <= 1'b0;
    end
    tx_gap = gap_now;
  end

  // colour receiver
  always @(negedge clk) begin
    if (!rst_n || out_hold) begin
      out_bus.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_bus.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      rx_gap <= $urandom_range(0, 3);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  initial begin : receiver_hold
    wait (hold_go);
    out_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    out_hold = 1'b0;
  end

  always @(posedge clk) begin : monitor
    colour_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        if (ticks_pending.size() > 0) void'(ticks_pending.pop_front());
        colour_due.push_back(animate_tick(in_bus.elapsed_ticks, in_bus.restart));
      end
      if (out_bus.valid && out_bus.ready) begin
        if (colour_due.size() == 0) begin
          $error("colour transfer with no tick outstanding");
          mismatches++;
        end else begin
          want = colour_due.pop_front();
          check_field("red_level", want.red, out_bus.red_level);
          check_field("green_level", want.green, out_bus.green_level);
          check_field("blue_level", want.blue, out_bus.blue_level);
          check_field("bright_level", want.bright, out_bus.bright_level);
          check_field("current_key", want.key, out_bus.current_key);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.elapsed_ticks = '0;
    in_bus.restart = 1'b0;
    out_bus.ready = 1'b0;
    key_count_m = CNT_W'(1);
    foreach (key_mem[k]) key_mem[k] = '0;
    anim_key = '0;
    anim_time = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // three keys: zero duration in the middle, widest duration last
    reg_write(REG_KEY_COUNT, 64'd3);
    reg_write(REG_KEY_WORD0, 64'h0004_00FF_8010);
    reg_write(REG_KEY_WORD0 + 3'd1, 64'h0000_FF00_80FF);
    reg_write(REG_KEY_WORD0 + 3'd2, 64'hFFFF_FFFF_0000);
    @(posedge clk);
    queue_tick(0, 0);
    queue_tick(1, 0);
    queue_tick(2, 0);
    queue_tick(1, 0);
    queue_tick(1, 0);
    queue_tick(255, 0);
    queue_tick(255, 1);
    queue_tick(0, 1);
    queue_tick(128, 0);

    // count dropped below the current key
    wait_idle();
    reg_write(REG_KEY_COUNT, 64'd1);
    @(posedge clk);
    queue_tick(0, 0);
    queue_tick(7, 0);
    queue_tick(255, 1);

    // count of zero, spare register address
    wait_idle();
    reg_write(REG_KEY_COUNT, 64'd0);
    reg_write(REG_KEY_WORD0, 64'h0000_0000_0000);
    reg_write(REG_SPARE, '1);
    @(posedge clk);
    queue_tick(255, 0);
    queue_tick(1, 0);

    // count above the key limit
    wait_idle();
    reg_write(REG_KEY_COUNT, 64'd7);
    reg_write(REG_KEY_WORD0, 64'h0001_0000_0000);
    reg_write(REG_KEY_WORD0 + 3'd2, 64'h0040_FFFF_0000);
    reg_write(REG_KEY_WORD0 + 3'd3, 64'h0001_FFFF_FFFF);
    reg_write(REG_KEY_WORD0 + 3'd4, 64'h0002_0000_0000);
    reg_write(REG_KEY_WORD0 + 3'd5, 64'h0003_FFFF_FFFF);
    @(posedge clk);
    queue_tick(255, 0);
    queue_tick(3, 0);
    queue_tick(7, 0);
    queue_tick(200, 0);
    queue_tick(255, 1);
    queue_tick(0, 0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      idling = (p != 3) && (p < PHASES - 2);
      if (p == 2) hold_go = 1'b1;
      if (p == 5) begin
        random_phase(PHASE_KEYS[p], span_mode_t'(p % 4), PHASE_TICKS / 2, 1'b0);
        wait_idle();
        random_phase(PHASE_KEYS[p], span_mode_t'(p % 4), PHASE_TICKS / 2, 1'b1);
      end else begin
        random_phase(PHASE_KEYS[p], span_mode_t'(p % 4), PHASE_TICKS, 1'b0);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/kca_pkg.sv
hdl/kca_chan_if.sv
hdl/kca_regs.sv
hdl/kca_ctrl.sv
hdl/kca_dp.sv
hdl/keyframe_colour_animator.sv
tb/tb_top.sv
